>>> rtl/core/set_of_bounded_stacks_assert.svh
// assertion macros for the set of bounded stacks
`ifndef SET_OF_BOUNDED_STACKS_ASSERT_SVH
`define SET_OF_BOUNDED_STACKS_ASSERT_SVH

// same-cycle implication
`define SOBS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SOBS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sobs_pkg.sv
// ----------------------------------------------------------------------------
// sobs_pkg
// Types, sizes and codes shared by the set-of-bounded-stacks modules.
// ----------------------------------------------------------------------------
package sobs_pkg;

   localparam int MAX_STACKS  = 16;
   localparam int MAX_DEPTH   = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int STACK_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int FILL_W  = $clog2(MAX_DEPTH + 1);
   localparam int CNT_W   = $clog2(MAX_STACKS + 1);
   localparam int ADDR_W  = (MAX_STACKS * MAX_DEPTH > 1) ?
                            $clog2(MAX_STACKS * MAX_DEPTH) : 1;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   // fixed field widths
   localparam int WORD_W  = 32;
   localparam int KIND_W  = 2;
   localparam int INDEX_W = 4;
   localparam int STAT_W  = 2;
   localparam int OPEN_W  = 5;
   localparam int CAP_W   = 5;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // register word indexes
   localparam logic [CSR_AW-3:0] REG_CAPACITY = '0;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP_LAST  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_NAMED = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_POP_LAST  = 2'd1,
      OP_POP_NAMED = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] push_value;
      logic [INDEX_W-1:0]       stack_index;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [STAT_W-1:0]        status;
      logic [OPEN_W-1:0]        open_stacks;
   } rsp_type;

   typedef struct packed {
      op_type                   op;
      logic signed [WORD_W-1:0] value;
      logic [INDEX_W-1:0]       index;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [STACK_W-1:0] s,
                                                   input logic [FILL_W-1:0]  slot);
      word_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_DEPTH) + ADDR_W'(slot));
   endfunction

endpackage

>>> rtl/core/sobs_csr.sv
// ----------------------------------------------------------------------------
// sobs_csr
// Capacity register on the APB-style port, with the clamped working value.
// ----------------------------------------------------------------------------
module sobs_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sobs_pkg::CSR_AW-1:0] paddr,
   input  logic [sobs_pkg::CSR_DW-1:0] pwdata,
   output logic [sobs_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output logic [sobs_pkg::FILL_W-1:0] cap_eff
);
   import sobs_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             is_cap;

   assign pready = 1'b1;
   assign is_cap = (paddr[CSR_AW-1:2] == REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && pready && is_cap) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (is_cap) begin
         prdata = CSR_DW'(cap_ff);
      end
   end

   // zero acts as one, anything past the slot count acts as the slot count
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = FILL_W'(1);
      end else if (32'(cap_ff) > 32'(MAX_DEPTH)) begin
         cap_eff = FILL_W'(MAX_DEPTH);
      end else begin
         cap_eff = FILL_W'(cap_ff);
      end
   end

endmodule

>>> rtl/core/sobs_front.sv
// ----------------------------------------------------------------------------
// sobs_front
// Takes request beats, decodes the kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module sobs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sobs_pkg::req_type       req_data,
   output sobs_pkg::queue_out_type q,
   input  logic                    q_pop
);
   import sobs_pkg::*;

   item_type          ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              pop;
   item_type          dec;

   assign req_stall = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != '0);

   always_comb begin
      dec.value = req_data.push_value;
      dec.index = req_data.stack_index;
      unique case (req_data.kind)
         KIND_PUSH:      dec.op = OP_PUSH;
         KIND_POP_LAST:  dec.op = OP_POP_LAST;
         KIND_POP_NAMED: dec.op = OP_POP_NAMED;
         default:        dec.op = OP_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

   assign q.valid = (cnt_ff != '0);
   assign q.item  = ent_ff[rd_ptr_ff];

endmodule

>>> rtl/core/sobs_back.sv
// ----------------------------------------------------------------------------
// sobs_back
// Carries out queued operations on the fill counts and the word store and
// delivers one result beat per operation.
// ----------------------------------------------------------------------------
module sobs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sobs_pkg::queue_out_type     q,
   output logic                        q_pop,
   input  logic [sobs_pkg::FILL_W-1:0] cap_eff,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sobs_pkg::rsp_type           rsp_data
);
   import sobs_pkg::*;

   logic [FILL_W-1:0]        fill_ff [MAX_STACKS];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [WORD_W-1:0] store_mem [MAX_STACKS * MAX_DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   logic                     mid_valid_ff, mid_pop_ff;
   logic [STAT_W-1:0]        mid_status_ff;
   logic [CNT_W-1:0]         mid_open_ff;
   logic                     out_valid_ff;
   rsp_type                  out_ff;

   logic                     fire, mid_move, has;
   logic [STACK_W-1:0]       last, target, fill_wi;
   logic [FILL_W-1:0]        f, fill_wv;
   logic                     fill_we, st_we, st_re;
   logic [ADDR_W-1:0]        st_wa, st_ra;
   logic [STAT_W-1:0]        status;

   assign mid_move = mid_valid_ff && (!out_valid_ff || !rsp_stall);
   assign fire     = q.valid && (!mid_valid_ff || mid_move);
   assign q_pop    = fire;

   assign has    = (count_ff != '0);
   assign last   = STACK_W'(count_ff - 1'b1);
   assign target = (q.item.op == OP_POP_NAMED) ? STACK_W'(q.item.index) : last;
   assign f      = fill_ff[target];

   always_comb begin
      status   = ST_OK;
      count_in = count_ff;
      fill_we  = 1'b0;
      fill_wi  = last;
      fill_wv  = f;
      st_we    = 1'b0;
      st_wa    = word_addr(last, f);
      st_re    = 1'b0;
      st_ra    = word_addr(target, FILL_W'(f - 1'b1));
      unique case (q.item.op)
         OP_PUSH: begin
            if (has && (f < cap_eff)) begin
               st_we   = 1'b1;
               fill_we = 1'b1;
               fill_wv = FILL_W'(f + 1'b1);
            end else if (count_ff >= CNT_W'(MAX_STACKS)) begin
               status = ST_FULL;
            end else begin
               // open a new sub-stack
               st_we    = 1'b1;
               st_wa    = word_addr(STACK_W'(count_ff), '0);
               fill_we  = 1'b1;
               fill_wi  = STACK_W'(count_ff);
               fill_wv  = FILL_W'(1);
               count_in = CNT_W'(count_ff + 1'b1);
            end
         end
         OP_POP_LAST: begin
            if (!has || (f == '0)) begin
               status = ST_EMPTY;
            end else begin
               st_re   = 1'b1;
               fill_we = 1'b1;
               fill_wv = FILL_W'(f - 1'b1);
               if (f == FILL_W'(1)) begin
                  count_in = CNT_W'(count_ff - 1'b1);
               end
            end
         end
         OP_POP_NAMED: begin
            if (CNT_W'(q.item.index) >= count_ff) begin
               status = ST_BAD_INDEX;
            end else if (f == '0) begin
               status = ST_EMPTY;
            end else begin
               st_re   = 1'b1;
               fill_we = 1'b1;
               fill_wi = target;
               fill_wv = FILL_W'(f - 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (fire) begin
         count_ff <= count_in;
         if (fill_we) begin
            fill_ff[fill_wi] <= fill_wv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && st_we) begin
         store_mem[st_wa] <= q.item.value;
      end
      if (fire && st_re) begin
         rd_data_ff <= store_mem[st_ra];
      end
   end

   // decision stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (fire) begin
         mid_valid_ff <= 1'b1;
      end else if (mid_move) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mid_status_ff <= status;
         mid_open_ff   <= count_in;
         mid_pop_ff    <= st_re;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (mid_move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_move) begin
         out_ff.popped_value <= mid_pop_ff ? rd_data_ff : '0;
         out_ff.status       <= mid_status_ff;
         out_ff.open_stacks  <= OPEN_W'(mid_open_ff);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/core/set_of_bounded_stacks.sv
// ----------------------------------------------------------------------------
// set_of_bounded_stacks
// Ordered set of sub-stacks with a configurable capacity per sub-stack.
// ----------------------------------------------------------------------------
//   port group   role        handshake              beat
//   req_*        requests    req_valid / req_stall  req_type
//   rsp_*        results     rsp_valid / rsp_stall  rsp_type
//   p*           registers   psel / penable         capacity word
//
// one item per cycle sustained while rsp_stall is low; a request beat
// passes the queue entry, then the decision stage with the word store port,
// then the result register, which offers the result beat
// fill counts sit in flops, the word store has one write or read per cycle
// synchronous reset clears counts and queue; the word store is not cleared
// req_stall rises when the two-entry queue is full
`include "set_of_bounded_stacks_assert.svh"

module set_of_bounded_stacks (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sobs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sobs_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sobs_pkg::CSR_AW-1:0] paddr,
   input  logic [sobs_pkg::CSR_DW-1:0] pwdata,
   output logic [sobs_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import sobs_pkg::*;

   queue_out_type     q_link;
   logic              q_pop;
   logic [FILL_W-1:0] cap_eff;
   logic              full_beat;
   logic              err_beat;
   logic              at_max;
   logic              no_word;

   sobs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   sobs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q         (q_link),
      .q_pop     (q_pop)
   );

   sobs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q         (q_link),
      .q_pop     (q_pop),
      .cap_eff   (cap_eff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign full_beat = rsp_valid && (rsp_data.status == ST_FULL);
   assign err_beat  = rsp_valid && (rsp_data.status != ST_OK);
   assign at_max    = (rsp_data.open_stacks == OPEN_W'(MAX_STACKS));
   assign no_word   = (rsp_data.popped_value == '0);

   `SOBS_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "beat right after reset")
   `SOBS_ASSERT_IMP(a_stall_has_work, clock, reset, req_stall, q_link.valid, "stall, queue empty")
   `SOBS_ASSERT_IMP(a_full_count, clock, reset, full_beat, at_max, "full status below slot count")
   `SOBS_ASSERT_IMP(a_err_no_word, clock, reset, err_beat, no_word, "error result carries a word")

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for set_of_bounded_stacks. A directed table walks the
// corner cases, and phases of random push/pop traffic follow under several
// capacity settings. Every accepted request is run through an in-bench
// stack predictor, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sobs_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   set_of_bounded_stacks dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted stack contents
   logic signed [WORD_W-1:0] words [MAX_STACKS][MAX_DEPTH];
   int unsigned              fills [MAX_STACKS];
   int unsigned              open_cnt;
   logic [CAP_W-1:0]         cap_reg = CAP_RESET;

   rsp_type     pending_results [$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned burst_left = 0;

   typedef struct {
      logic [CAP_W-1:0]         cap;
      op_type                   op;
      logic signed [WORD_W-1:0] value;
      logic [INDEX_W-1:0]       index;
      bit                       typed;
      rsp_type                  want;
   } plan_row_type;

   plan_row_type plan [22] = '{
      '{5'd16, OP_POP_LAST,  32'h0,        4'd0,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
      '{5'd16, OP_POP_NAMED, 32'h0,        4'd0,  1'b1, '{32'h0, ST_BAD_INDEX, 5'd0}},
      '{5'd16, OP_NOP,       32'hffffffff, 4'd15, 1'b1, '{32'h0, ST_OK, 5'd0}},
      '{5'd16, OP_PUSH,      32'h7fffffff, 4'd0,  1'b1, '{32'h0, ST_OK, 5'd1}},
      '{5'd16, OP_PUSH,      32'h80000000, 4'd15, 1'b1, '{32'h0, ST_OK, 5'd1}},
      '{5'd16, OP_POP_NAMED, 32'h0,        4'd15, 1'b1, '{32'h0, ST_BAD_INDEX, 5'd1}},
      '{5'd16, OP_POP_LAST,  32'h0,        4'd0,  1'b1, '{32'h80000000, ST_OK, 5'd1}},
      '{5'd16, OP_POP_NAMED, 32'h0,        4'd0,  1'b1, '{32'h7fffffff, ST_OK, 5'd1}},
      '{5'd16, OP_POP_NAMED, 32'h0,        4'd0,  1'b1, '{32'h0, ST_EMPTY, 5'd1}},
      '{5'd16, OP_POP_LAST,  32'h0,        4'd0,  1'b1, '{32'h0, ST_EMPTY, 5'd1}},
      '{5'd16, OP_PUSH,      32'd5,        4'd0,  1'b0, '0},
      '{5'd0,  OP_PUSH,      32'd6,        4'd0,  1'b0, '0},
      '{5'd0,  OP_PUSH,      32'd7,        4'd0,  1'b0, '0},
      '{5'd31, OP_PUSH,      32'hffffffff, 4'd0,  1'b0, '0},
      '{5'd31, OP_PUSH,      32'h0,        4'd0,  1'b0, '0},
      '{5'd1,  OP_PUSH,      32'd1,        4'd0,  1'b0, '0},
      '{5'd1,  OP_POP_LAST,  32'h0,        4'd0,  1'b0, '0},
      '{5'd1,  OP_POP_NAMED, 32'h0,        4'd3,  1'b0, '0},
      '{5'd1,  OP_POP_NAMED, 32'h0,        4'd1,  1'b0, '0},
      '{5'd1,  OP_POP_LAST,  32'h0,        4'd0,  1'b0, '0},
      '{5'd1,  OP_POP_LAST,  32'h0,        4'd0,  1'b0, '0},
      '{5'd1,  OP_POP_LAST,  32'h0,        4'd0,  1'b0, '0}
   };

   task automatic note_error(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic rsp_type predict_stack_op(input req_type r);
      int unsigned cap;
      int unsigned top;
      int unsigned idx;
      rsp_type     res;
      cap = (cap_reg == 0) ? 1 : (cap_reg > MAX_DEPTH) ? MAX_DEPTH : cap_reg;
      idx = r.stack_index;
      res.popped_value = '0;
      res.status = ST_OK;
      case (op_type'(r.kind))
         OP_PUSH: begin
            if (open_cnt > 0 && fills[open_cnt-1] < cap) begin
               top = open_cnt - 1;
               words[top][fills[top]] = r.push_value;
               fills[top]++;
            end else if (open_cnt >= MAX_STACKS) begin
               res.status = ST_FULL;
            end else begin
               words[open_cnt][0] = r.push_value;
               fills[open_cnt] = 1;
               open_cnt++;
            end
         end
         OP_POP_LAST: begin
            if (open_cnt == 0 || fills[open_cnt-1] == 0) begin
               res.status = ST_EMPTY;
            end else begin
               top = open_cnt - 1;
               fills[top]--;
               res.popped_value = words[top][fills[top]];
               if (fills[top] == 0) open_cnt = top;
            end
         end
         OP_POP_NAMED: begin
            if (idx >= open_cnt) begin
               res.status = ST_BAD_INDEX;
            end else if (fills[idx] == 0) begin
               res.status = ST_EMPTY;
            end else begin
               fills[idx]--;
               res.popped_value = words[idx][fills[idx]];
            end
         end
         default: ;
      endcase
      res.open_stacks = OPEN_W'(open_cnt);
      return res;
   endfunction

   // one request beat; the sender runs in bursts with idle gaps between them
   task automatic send_beat(input req_type r, input bit typed, input rsp_type want);
      rsp_type exp;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      exp = predict_stack_op(r);
      if (typed) exp = want;
      pending_results = {pending_results, exp};
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {REG_CAPACITY, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // capacity changes only once the block has drained
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      logic [CSR_DW-1:0] rd;
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_access(1'b1, CSR_DW'(cap), rd);
      cap_reg = cap;
      @(posedge clock);
      csr_access(1'b0, '0, rd);
      if (rd != CSR_DW'(cap))
         note_error($sformatf("capacity readback %0d, wrote %0d", rd, cap));
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            note_error("result beat with nothing pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.popped_value !== want.popped_value)
               note_error($sformatf("popped_value %h, expected %h",
                                    rsp_data.popped_value, want.popped_value));
            if (rsp_data.status !== want.status)
               note_error($sformatf("status %0d, expected %0d",
                                    rsp_data.status, want.status));
            if (rsp_data.open_stacks !== want.open_stacks)
               note_error($sformatf("open_stacks %0d, expected %0d",
                                    rsp_data.open_stacks, want.open_stacks));
         end
      end
   end

   // receiver stall pattern, with one long hold so the input side backs up
   initial begin : rsp_side
      int unsigned run_len;
      int unsigned pct;
      bit          held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 300) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end
         run_len = $urandom_range(5, 60);
         case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 30;
            default: pct = 75;
         endcase
         repeat (run_len) begin
            rsp_stall <= ($urandom_range(0, 99) < pct);
            @(posedge clock);
         end
      end
   end

   initial begin : limit
      #1_000_000;
      $display("** set_of_bounded_stacks: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [CAP_W-1:0]  phase_caps [6];
      int unsigned       push_pcts [10];
      logic [CSR_DW-1:0] rd;
      req_type           r;
      int unsigned       roll;
      int unsigned       push_pct;
      logic [CAP_W-1:0]  cap;

      phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd7};
      push_pcts = '{85, 85, 30, 60, 25, 80, 40, 70, 30, 60};
      open_cnt = 0;
      foreach (fills[i]) fills[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0, rd);
      if (rd != CSR_DW'(CAP_RESET))
         note_error($sformatf("capacity after reset %0d", rd));

      foreach (plan[i]) begin
         if (plan[i].cap != cap_reg) set_capacity(plan[i].cap);
         r.kind = plan[i].op;
         r.push_value = plan[i].value;
         r.stack_index = plan[i].index;
         send_beat(r, plan[i].typed, plan[i].want);
      end

      for (int phase = 0; phase < 10; phase++) begin
         cap = (phase < 6) ? phase_caps[phase] : CAP_W'($urandom_range(0, 31));
         set_capacity(cap);
         push_pct = push_pcts[phase];
         for (int n = 0; n < 200; n++) begin
            r.push_value = $urandom;
            r.stack_index = INDEX_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
               r.kind = OP_PUSH;
            end else if (roll < push_pct + (100 - push_pct) / 2) begin
               r.kind = OP_POP_LAST;
            end else if (roll < 96) begin
               r.kind = OP_POP_NAMED;
               // mostly aim at an open sub-stack
               if (open_cnt > 0 && $urandom_range(0, 3) != 0)
                  r.stack_index = INDEX_W'($urandom_range(0, open_cnt - 1));
            end else begin
               r.kind = OP_NOP;
            end
            send_beat(r, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("** set_of_bounded_stacks: PASSED **");
      else
         $display("** set_of_bounded_stacks: FAILED **");
      $finish;
   end

endmodule
